// ===== hdl/cpd_pkg.sv =====
// Package for the CRC-checked packet deframer.
// Holds the shared constants, the controller state type, the command and
// status structs between controller and datapath, and the CRC-16 byte update.
package cpd_pkg;

   localparam int MAX_PAYLOAD   = 64;
   localparam int MAX_FRAME_LEN = 68;
   localparam int HEADER_LEN    = 4;
   localparam int PAYLOAD_AW    = 6;
   localparam int CNT_W         = 7;
   localparam int RSP_DATA_W    = 40;

   localparam logic [15:0] CRC_POLY           = 16'hA001;
   localparam logic [7:0]  START_MARKER_RESET = 8'hAA;

   typedef enum logic [3:0] {
      ST_HUNT,
      ST_LEN_LO,
      ST_LEN_HI,
      ST_CMD_LO,
      ST_CMD_HI,
      ST_DATA,
      ST_CRC_LO,
      ST_CRC_HI,
      ST_EMIT_RD,
      ST_EMIT_LD
   } state_type;

   typedef struct packed {
      logic crc_init;
      logic crc_feed;
      logic len_lo_ld;
      logic len_hi_ld;
      logic cmd_lo_ld;
      logic cmd_hi_ld;
      logic cnt_clr;
      logic data_wr;
      logic crc_lo_ld;
      logic idx_clr;
      logic rd_en;
      logic out_ld;
   } cmd_type;

   typedef struct packed {
      logic marker_hit;
      logic len_too_big;
      logic len_bad;
      logic len_is_min;
      logic data_done;
      logic crc_ok;
      logic plen_zero;
      logic emit_last;
      logic out_busy;
   } status_type;

   // CRC-16/ARC update for one byte, reflected, bit at a time.
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

// ===== hdl/cpd_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Stands alone; used for the payload buffer of the deframer.
module cpd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/cpd_datapath.sv =====
// Datapath of the deframer: header and CRC registers, payload buffer,
// byte counters and the result register. Depends on cpd_pkg and cpd_ram.
module cpd_datapath (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [7:0]                      csr_wdata,
   input  logic [7:0]                      rx_byte,
   input  cpd_pkg::cmd_type                cmd,
   output cpd_pkg::status_type             status,
   input  logic                            rsp_tready,
   output logic                            rsp_tvalid,
   output logic [cpd_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic                            rsp_tuser,
   output logic                            rsp_tlast
);

   logic [7:0]                      marker_ff, marker_in;
   logic [15:0]                     frame_len_ff, frame_len_in;
   logic [15:0]                     command_ff, command_in;
   logic [15:0]                     crc_ff, crc_in;
   logic [7:0]                      crc_lo_ff, crc_lo_in;
   logic [cpd_pkg::CNT_W-1:0]       count_ff, count_in;
   logic [cpd_pkg::PAYLOAD_AW-1:0]  idx_ff, idx_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [cpd_pkg::RSP_DATA_W-1:0]  rsp_data_ff, rsp_data_in;
   logic                            rsp_user_ff, rsp_user_in;
   logic                            rsp_last_ff, rsp_last_in;

   logic [cpd_pkg::CNT_W-1:0]       plen;
   logic [cpd_pkg::CNT_W-1:0]       count_inc;
   logic [cpd_pkg::CNT_W-1:0]       idx_inc;
   logic [15:0]                     len_full;
   logic [7:0]                      ram_rd_data;
   logic                            has_data;
   logic                            emit_last;

   cpd_ram #(
      .WIDTH(8),
      .DEPTH(cpd_pkg::MAX_PAYLOAD)
   ) u_payload_ram (
      .clock   (clock),
      .wr_en   (cmd.data_wr),
      .wr_addr (count_ff[cpd_pkg::PAYLOAD_AW-1:0]),
      .wr_data (rx_byte),
      .rd_en   (cmd.rd_en),
      .rd_addr (idx_ff),
      .rd_data (ram_rd_data)
   );

   // Payload length is only meaningful once the frame length is within limits,
   // so the low bits of the length are enough.
   assign plen      = frame_len_ff[cpd_pkg::CNT_W-1:0] - cpd_pkg::CNT_W'(cpd_pkg::HEADER_LEN);
   assign count_inc = count_ff + 1'b1;
   assign idx_inc   = {1'b0, idx_ff} + 1'b1;
   assign len_full  = {rx_byte, frame_len_ff[7:0]};
   assign has_data  = (plen != '0);
   assign emit_last = has_data ? (idx_inc == plen) : 1'b1;

   always_comb begin
      status.marker_hit  = (rx_byte == marker_ff);
      status.len_too_big = (len_full > 16'(cpd_pkg::MAX_FRAME_LEN));
      status.len_bad     = (frame_len_ff < 16'(cpd_pkg::HEADER_LEN)) ||
                           (frame_len_ff > 16'(cpd_pkg::MAX_FRAME_LEN));
      status.len_is_min  = (frame_len_ff == 16'(cpd_pkg::HEADER_LEN));
      status.data_done   = (count_inc >= plen);
      status.crc_ok      = ({rx_byte, crc_lo_ff} == crc_ff);
      status.plen_zero   = !has_data;
      status.emit_last   = emit_last;
      status.out_busy    = rsp_valid_ff && !rsp_tready;
   end

   always_comb begin
      marker_in    = csr_we ? csr_wdata : marker_ff;
      frame_len_in = frame_len_ff;
      command_in   = command_ff;
      crc_in       = crc_ff;
      crc_lo_in    = crc_lo_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      rsp_last_in  = rsp_last_ff;

      if (cmd.crc_init) begin
         crc_in = cpd_pkg::crc_byte(16'h0000, rx_byte);
      end else if (cmd.crc_feed) begin
         crc_in = cpd_pkg::crc_byte(crc_ff, rx_byte);
      end
      if (cmd.len_lo_ld) begin
         frame_len_in = {8'h00, rx_byte};
      end
      if (cmd.len_hi_ld) begin
         frame_len_in = len_full;
      end
      if (cmd.cmd_lo_ld) begin
         command_in = {8'h00, rx_byte};
      end
      if (cmd.cmd_hi_ld) begin
         command_in = {rx_byte, command_ff[7:0]};
      end
      if (cmd.cnt_clr) begin
         count_in = '0;
      end else if (cmd.data_wr) begin
         count_in = count_inc;
      end
      if (cmd.crc_lo_ld) begin
         crc_lo_in = rx_byte;
      end
      if (cmd.idx_clr) begin
         idx_in = '0;
      end else if (cmd.out_ld) begin
         idx_in = idx_inc[cpd_pkg::PAYLOAD_AW-1:0];
      end
      if (cmd.out_ld) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {3'b000,
                         has_data ? idx_ff : cpd_pkg::PAYLOAD_AW'(0),
                         has_data ? ram_rd_data : 8'h00,
                         plen,
                         command_ff};
         rsp_user_in  = has_data;
         rsp_last_in  = emit_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         marker_ff    <= cpd_pkg::START_MARKER_RESET;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         marker_ff    <= marker_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      frame_len_ff <= frame_len_in;
      command_ff   <= command_in;
      crc_ff       <= crc_in;
      crc_lo_ff    <= crc_lo_in;
      idx_ff       <= idx_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_user_ff  <= rsp_user_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ===== hdl/cpd_ctrl.sv =====
// Controller state machine of the deframer: walks the packet fields and the
// result run, and issues datapath commands. Depends on cpd_pkg.
module cpd_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  cpd_pkg::status_type  status,
   output cpd_pkg::cmd_type     cmd
);

   cpd_pkg::state_type state_ff, state_in;
   logic               accept;

   always_comb begin
      case (state_ff)
         cpd_pkg::ST_EMIT_RD,
         cpd_pkg::ST_EMIT_LD: begin
            req_tready = 1'b0;
         end
         default: begin
            req_tready = 1'b1;
         end
      endcase
   end

   assign accept = req_tvalid && req_tready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         cpd_pkg::ST_HUNT: begin
            if (accept && status.marker_hit) begin
               state_in = cpd_pkg::ST_LEN_LO;
            end
         end
         cpd_pkg::ST_LEN_LO: begin
            if (accept) begin
               state_in = cpd_pkg::ST_LEN_HI;
            end
         end
         cpd_pkg::ST_LEN_HI: begin
            if (accept) begin
               state_in = status.len_too_big ? cpd_pkg::ST_HUNT : cpd_pkg::ST_CMD_LO;
            end
         end
         cpd_pkg::ST_CMD_LO: begin
            if (accept) begin
               state_in = cpd_pkg::ST_CMD_HI;
            end
         end
         cpd_pkg::ST_CMD_HI: begin
            if (accept) begin
               if (status.len_bad) begin
                  state_in = cpd_pkg::ST_HUNT;
               end else if (status.len_is_min) begin
                  state_in = cpd_pkg::ST_CRC_LO;
               end else begin
                  state_in = cpd_pkg::ST_DATA;
               end
            end
         end
         cpd_pkg::ST_DATA: begin
            if (accept && status.data_done) begin
               state_in = cpd_pkg::ST_CRC_LO;
            end
         end
         cpd_pkg::ST_CRC_LO: begin
            if (accept) begin
               state_in = cpd_pkg::ST_CRC_HI;
            end
         end
         cpd_pkg::ST_CRC_HI: begin
            if (accept) begin
               if (!status.crc_ok) begin
                  state_in = cpd_pkg::ST_HUNT;
               end else if (status.plen_zero) begin
                  state_in = cpd_pkg::ST_EMIT_LD;
               end else begin
                  state_in = cpd_pkg::ST_EMIT_RD;
               end
            end
         end
         cpd_pkg::ST_EMIT_RD: begin
            state_in = cpd_pkg::ST_EMIT_LD;
         end
         cpd_pkg::ST_EMIT_LD: begin
            if (!status.out_busy) begin
               state_in = status.emit_last ? cpd_pkg::ST_HUNT : cpd_pkg::ST_EMIT_RD;
            end
         end
         default: begin
            state_in = cpd_pkg::ST_HUNT;
         end
      endcase
   end

   // Datapath commands.
   always_comb begin
      cmd = '0;
      case (state_ff)
         cpd_pkg::ST_HUNT: begin
            cmd.crc_init = accept && status.marker_hit;
         end
         cpd_pkg::ST_LEN_LO: begin
            cmd.crc_feed  = accept;
            cmd.len_lo_ld = accept;
         end
         cpd_pkg::ST_LEN_HI: begin
            cmd.crc_feed  = accept;
            cmd.len_hi_ld = accept;
         end
         cpd_pkg::ST_CMD_LO: begin
            cmd.crc_feed  = accept;
            cmd.cmd_lo_ld = accept;
         end
         cpd_pkg::ST_CMD_HI: begin
            cmd.crc_feed  = accept;
            cmd.cmd_hi_ld = accept;
            cmd.cnt_clr   = accept;
         end
         cpd_pkg::ST_DATA: begin
            cmd.crc_feed = accept;
            cmd.data_wr  = accept;
         end
         cpd_pkg::ST_CRC_LO: begin
            cmd.crc_lo_ld = accept;
         end
         cpd_pkg::ST_CRC_HI: begin
            cmd.idx_clr = accept;
         end
         cpd_pkg::ST_EMIT_RD: begin
            cmd.rd_en = 1'b1;
         end
         cpd_pkg::ST_EMIT_LD: begin
            cmd.out_ld = !status.out_busy;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cpd_pkg::ST_HUNT;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== hdl/crc_checked_packet_deframer.sv =====
// Top level of the CRC-checked packet deframer.
// Depends on cpd_pkg, cpd_ctrl, cpd_datapath and cpd_ram.
//
// Usage: received bytes enter one request at a time on the req_ channel. The
// deframer hunts for the start marker (csr_wdata written with csr_we high sets
// it; 0xAA after reset), then reads a little-endian 16-bit length, a 16-bit
// command, length minus four payload bytes and a little-endian CRC-16/ARC over
// every byte from the marker through the payload. Bad lengths and CRC
// mismatches drop the packet without any result.
// While a packet is parsed req_tready is high and each byte is taken as soon as
// it is valid. After the final CRC byte of a good packet is accepted, a payload
// byte is read from the buffer in ST_EMIT_RD and its result is loaded into the
// output register in ST_EMIT_LD once that is free; further results, one per
// payload byte, repeat this read and load, paced by the registered read of the
// buffer. An empty payload skips the read and gives a single result with
// rsp_tuser low. During a run req_tready is low; after the last result is
// loaded, new bytes are accepted again even if that result still waits in the
// output register. When the receiver stalls, the current result holds there
// and the run pauses. Reset, synchronous and active high, returns the parser
// to hunting, empties the output register and restores the start marker.
module crc_checked_packet_deframer (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [7:0]                      csr_wdata,   // start marker
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [7:0]                      req_tdata,   // [7:0] rx_byte
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [15:0] command, [22:16] payload_len, [30:23] data_byte,
   // [36:31] byte_index, [39:37] zero
   output logic [cpd_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic                            rsp_tuser,   // [0] has_data
   output logic                            rsp_tlast    // last result of the run
);

   cpd_pkg::cmd_type    cmd;
   cpd_pkg::status_type status;

   cpd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   cpd_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .rx_byte    (req_tdata),
      .cmd        (cmd),
      .status     (status),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // A result without payload data is always the whole run by itself.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tlast && rsp_tdata[22:16] == 7'd0)
      else $error("empty-payload result is not a lone last result");

   // A payload byte always lies inside its packet's payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> {1'b0, rsp_tdata[36:31]} < rsp_tdata[22:16])
      else $error("byte index beyond payload length");

   // Payload length never exceeds the buffer size.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[22:16] <= 7'(cpd_pkg::MAX_PAYLOAD))
      else $error("payload length above limit");

   // A data result marked last carries the final index of the payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser && rsp_tlast |->
         {1'b0, rsp_tdata[36:31]} + 7'd1 == rsp_tdata[22:16])
      else $error("last flag on a result that is not the final payload byte");

endmodule
